[hdl/tsp_pkg.sv]
// shared constants and the arctangent table for the three-step phase retrieval unit
package tsp_pkg;

	localparam int SAMPLE_BITS_DEF  = 12;
	localparam int ANGLE_STAGES_DEF = 16;

	// growth headroom of the x/y datapath above the sample width
	localparam int XY_GUARD = 19;

	// angle accumulator, units of pi/2^23
	localparam int Z_W       = 26;
	localparam int PHASE_W   = 16;
	localparam int TABLE_LEN = 24;

	// round(sqrt(3) * 2^15), with a zero sign bit on top
	localparam logic [17:0] SQRT3_Q15 = 18'd56756;

	localparam int FRAC_SHIFT = 15;

	localparam logic signed [Z_W-1:0] HALF_PI_Z  = 26'sd4194304;
	localparam logic signed [Z_W-1:0] ROUND_BIAS = 26'sd128;
	localparam int                    ROUND_SHIFT = 8;

	// atan(2^-i) * 2^23 / pi, rounded
	function automatic logic signed [Z_W-1:0] atan_entry(input int idx);
		logic signed [Z_W-1:0] val;
		begin
			case (idx)
				0:       val = 26'sd2097152;
				1:       val = 26'sd1238021;
				2:       val = 26'sd654136;
				3:       val = 26'sd332050;
				4:       val = 26'sd166669;
				5:       val = 26'sd83416;
				6:       val = 26'sd41718;
				7:       val = 26'sd20860;
				8:       val = 26'sd10430;
				9:       val = 26'sd5215;
				10:      val = 26'sd2608;
				11:      val = 26'sd1304;
				12:      val = 26'sd652;
				13:      val = 26'sd326;
				14:      val = 26'sd163;
				15:      val = 26'sd81;
				16:      val = 26'sd41;
				17:      val = 26'sd20;
				18:      val = 26'sd10;
				19:      val = 26'sd5;
				20:      val = 26'sd3;
				21:      val = 26'sd1;
				22:      val = 26'sd1;
				default: val = 26'sd0;
			endcase
			return val;
		end
	endfunction

endpackage

[hdl/tsp_front.sv]
// front cell: forms y and x from the three samples and folds the left half-plane
module tsp_front import tsp_pkg::*; #(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int XY_W        = SAMPLE_BITS_DEF + XY_GUARD
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [SAMPLE_BITS-1:0]        sample_a,
	input  logic [SAMPLE_BITS-1:0]        sample_b,
	input  logic [SAMPLE_BITS-1:0]        sample_c,
	input  logic                          last_pixel,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [XY_W-1:0]        out_x,
	output logic signed [XY_W-1:0]        out_y,
	output logic signed [Z_W-1:0]         out_z,
	output logic                          out_zero,
	output logic                          out_last
);

	localparam int D_W = SAMPLE_BITS + 1;
	localparam int E_W = SAMPLE_BITS + 3;
	localparam int P_W = D_W + 18;

	logic signed [D_W-1:0]  diff_ac;
	logic signed [E_W-1:0]  diff_x;
	logic signed [P_W-1:0]  prod_y;
	logic signed [XY_W-1:0] y_raw;
	logic signed [XY_W-1:0] x_raw;
	logic signed [XY_W-1:0] x_rot;
	logic signed [XY_W-1:0] y_rot;
	logic signed [Z_W-1:0]  z_rot;

	logic                   valid_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;
	logic                   zero_q;
	logic                   last_q;

	always_comb begin
		diff_ac = $signed({1'b0, sample_a}) - $signed({1'b0, sample_c});
		diff_x  = $signed({2'b00, sample_b, 1'b0}) - $signed({3'b000, sample_a})
			- $signed({3'b000, sample_c});
		prod_y  = diff_ac * $signed(SQRT3_Q15);
		y_raw   = XY_W'(prod_y);
		x_raw   = XY_W'(diff_x) <<< FRAC_SHIFT;
		// left half-plane: turn by a quarter and credit the turn
		if (x_raw[XY_W-1]) begin
			if (!y_raw[XY_W-1]) begin
				x_rot = y_raw;
				y_rot = -x_raw;
				z_rot = HALF_PI_Z;
			end else begin
				x_rot = -y_raw;
				y_rot = x_raw;
				z_rot = -HALF_PI_Z;
			end
		end else begin
			x_rot = x_raw;
			y_rot = y_raw;
			z_rot = '0;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_q    <= x_rot;
			y_q    <= y_rot;
			z_q    <= z_rot;
			zero_q <= (diff_ac == '0) && (diff_x == '0);
			last_q <= last_pixel;
		end
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;
	assign out_zero  = zero_q;
	assign out_last  = last_q;

endmodule

[hdl/tsp_cordic_cell.sv]
// one vectoring rotation cell of the arctangent chain
module tsp_cordic_cell import tsp_pkg::*; #(
	parameter int XY_W  = SAMPLE_BITS_DEF + XY_GUARD,
	parameter int STAGE = 0
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic signed [XY_W-1:0] in_x,
	input  logic signed [XY_W-1:0] in_y,
	input  logic signed [Z_W-1:0]  in_z,
	input  logic                   in_zero,
	input  logic                   in_last,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic signed [XY_W-1:0] out_x,
	output logic signed [XY_W-1:0] out_y,
	output logic signed [Z_W-1:0]  out_z,
	output logic                   out_zero,
	output logic                   out_last
);

	localparam logic signed [Z_W-1:0] ANGLE = atan_entry(STAGE);

	logic signed [XY_W-1:0] x_sh;
	logic signed [XY_W-1:0] y_sh;
	logic signed [XY_W-1:0] x_nxt;
	logic signed [XY_W-1:0] y_nxt;
	logic signed [Z_W-1:0]  z_nxt;

	logic                   valid_q;
	logic signed [XY_W-1:0] x_q;
	logic signed [XY_W-1:0] y_q;
	logic signed [Z_W-1:0]  z_q;
	logic                   zero_q;
	logic                   last_q;

	always_comb begin
		x_sh = in_x >>> STAGE;
		y_sh = in_y >>> STAGE;
		if (!in_y[XY_W-1]) begin
			x_nxt = in_x + y_sh;
			y_nxt = in_y - x_sh;
			z_nxt = in_z + ANGLE;
		end else begin
			x_nxt = in_x - y_sh;
			y_nxt = in_y + x_sh;
			z_nxt = in_z - ANGLE;
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			x_q    <= x_nxt;
			y_q    <= y_nxt;
			z_q    <= z_nxt;
			zero_q <= in_zero;
			last_q <= in_last;
		end
	end

	assign out_valid = valid_q;
	assign out_x     = x_q;
	assign out_y     = y_q;
	assign out_z     = z_q;
	assign out_zero  = zero_q;
	assign out_last  = last_q;

endmodule

[hdl/tsp_round.sv]
// output cell: rounds the angle to the 16-bit binary angle and holds the result item
module tsp_round import tsp_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [Z_W-1:0]     in_z,
	input  logic                      in_zero,
	input  logic                      in_last,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [PHASE_W-1:0] out_phase,
	output logic                      out_last
);

	logic signed [Z_W-1:0]     z_biased;
	logic signed [PHASE_W-1:0] phase_nxt;

	logic                      valid_q;
	logic signed [PHASE_W-1:0] phase_q;
	logic                      last_q;

	always_comb begin
		z_biased = in_z + ROUND_BIAS;
		// floor division by 256, kept modulo 2^16 so +pi wraps to -pi
		if (in_zero) begin
			phase_nxt = '0;
		end else begin
			phase_nxt = z_biased[ROUND_SHIFT +: PHASE_W];
		end
	end

	assign in_ready = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			phase_q <= phase_nxt;
			last_q  <= in_last;
		end
	end

	assign out_valid = valid_q;
	assign out_phase = phase_q;
	assign out_last  = last_q;

endmodule

[hdl/three_step_phase_retrieval_unit.sv]
// top level of the three-step phase retrieval unit
// Takes one pixel's three fringe intensities, shifted by 120 degrees, per item
// and returns the wrapped phase atan2(sqrt(3)*(a-c), 2b-a-c) as a signed 16-bit
// binary angle (phase * 32768 / pi, +pi wraps to -32768), with atan2(0,0) = 0.
// The datapath is a row of cells: a front cell that forms y and x (sqrt(3) as a
// Q1.15 constant, one small constant multiply) and folds the left half-plane,
// ANGLE_STAGES vectoring rotation cells that each do one shift-add step, and an
// output cell that rounds the angle and holds the result item. Every cell has
// its own valid bit and its own ready, so one item enters per clock and a
// stalled result only holds the cells behind it that are full. Throughput is
// one item per cycle while phase_ready stays high; an item passes through
// ANGLE_STAGES + 2 registers in a row: the front cell, the rotation cells
// and the output cell. last_pixel travels with its item and comes out as
// last_pixel_out. No state is kept between pixels.
module three_step_phase_retrieval_unit import tsp_pkg::*; #(
	parameter int SAMPLE_BITS  = SAMPLE_BITS_DEF,
	parameter int ANGLE_STAGES = ANGLE_STAGES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// pixel input channel
	input  logic                      sample_valid,
	output logic                      sample_ready,
	input  logic [SAMPLE_BITS-1:0]    sample_a,
	input  logic [SAMPLE_BITS-1:0]    sample_b,
	input  logic [SAMPLE_BITS-1:0]    sample_c,
	input  logic                      last_pixel,
	// phase output channel
	output logic                      phase_valid,
	input  logic                      phase_ready,
	output logic signed [PHASE_W-1:0] wrapped_phase,
	output logic                      last_pixel_out
);

	// x/y width: product of the sample difference and sqrt(3), plus rotation gain
	localparam int XY_W = SAMPLE_BITS + XY_GUARD;

	// chain links: link 0 leaves the front cell, link k leaves rotation cell k-1
	logic                   link_valid [ANGLE_STAGES+1];
	logic                   link_ready [ANGLE_STAGES+1];
	logic signed [XY_W-1:0] link_x     [ANGLE_STAGES+1];
	logic signed [XY_W-1:0] link_y     [ANGLE_STAGES+1];
	logic signed [Z_W-1:0]  link_z     [ANGLE_STAGES+1];
	logic                   link_zero  [ANGLE_STAGES+1];
	logic                   link_last  [ANGLE_STAGES+1];

	// front cell: y, x and the quarter turn for the left half-plane
	tsp_front #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.XY_W        (XY_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (sample_valid),
		.in_ready   (sample_ready),
		.sample_a   (sample_a),
		.sample_b   (sample_b),
		.sample_c   (sample_c),
		.last_pixel (last_pixel),
		.out_valid  (link_valid[0]),
		.out_ready  (link_ready[0]),
		.out_x      (link_x[0]),
		.out_y      (link_y[0]),
		.out_z      (link_z[0]),
		.out_zero   (link_zero[0]),
		.out_last   (link_last[0])
	);

	// rotation chain, one step of the vectoring iteration per cell
	for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cell
		tsp_cordic_cell #(
			.XY_W  (XY_W),
			.STAGE (k)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (link_valid[k]),
			.in_ready  (link_ready[k]),
			.in_x      (link_x[k]),
			.in_y      (link_y[k]),
			.in_z      (link_z[k]),
			.in_zero   (link_zero[k]),
			.in_last   (link_last[k]),
			.out_valid (link_valid[k+1]),
			.out_ready (link_ready[k+1]),
			.out_x     (link_x[k+1]),
			.out_y     (link_y[k+1]),
			.out_z     (link_z[k+1]),
			.out_zero  (link_zero[k+1]),
			.out_last  (link_last[k+1])
		);
	end

	// output cell: rounding to the binary angle, doubles as the output register
	tsp_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (link_valid[ANGLE_STAGES]),
		.in_ready  (link_ready[ANGLE_STAGES]),
		.in_z      (link_z[ANGLE_STAGES]),
		.in_zero   (link_zero[ANGLE_STAGES]),
		.in_last   (link_last[ANGLE_STAGES]),
		.out_valid (phase_valid),
		.out_ready (phase_ready),
		.out_phase (wrapped_phase),
		.out_last  (last_pixel_out)
	);

	// input is refused only when every cell is full and the result is stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> (link_valid[0] && link_valid[ANGLE_STAGES] && phase_valid
			&& !phase_ready))
		else $error("input refused while the chain has room");

	// an accepted item lands in the front cell
	assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> link_valid[0])
		else $error("accepted item lost at the front cell");

	// an item reaching the end of the chain is taken by the output cell or waits there
	assert property (@(posedge clk) disable iff (!arst_n)
		(link_valid[ANGLE_STAGES] && link_ready[ANGLE_STAGES]) |=> phase_valid)
		else $error("item lost between the chain and the output cell");

	// a pixel with both differences zero leaves the front cell with no angle credited
	assert property (@(posedge clk) disable iff (!arst_n)
		(link_valid[0] && link_zero[0]) |-> (link_z[0] == '0))
		else $error("zero vector given a quarter turn");

endmodule
